// ===== sv/aes128_block_cipher_defines.svh =====
// Assertion macros for the cipher checker
`ifndef AES128_BLOCK_CIPHER_DEFINES_SVH
`define AES128_BLOCK_CIPHER_DEFINES_SVH
// implication check on a clock with active-low reset
`define AES_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication check
`define AES_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== sv/aes_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 package
// Payload types, constants, S-box functions and round helpers.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned QueueDepth = 4;
  localparam logic [7:0] GfPolyLow = 8'h1b;
  localparam logic [7:0] GfTopBit = 8'h80;

  typedef enum logic {
    KIND_ENC = 1'b0,
    KIND_DEC = 1'b1
  } kind_t;

  typedef enum logic {
    CFG_KEY_HIGH = 1'b0,
    CFG_KEY_LOW  = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_item_t;

  // byte 0 sits in the top bits
  typedef logic [15:0][7:0] state_t;

  // work item handed from front to back
  typedef struct packed {
    logic   dec;
    state_t blk;
  } job_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = (a & GfTopBit) != 8'h00 ? ((a << 1) ^ GfPolyLow) : (a << 1);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] p;
    acc = 8'h00;
    p = b;
    for (int i = 0; i < 8; i++) begin
      if (a[i]) acc = acc ^ p;
      p = xtime(p);
    end
    gf_mul = acc;
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    sbox = t[x];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };
    inv_sbox = t[x];
  endfunction

  // byte i of a state_t at packed index 15-i
  function automatic logic [7:0] gb(input state_t s, input int i);
    gb = s[15 - i];
  endfunction

  function automatic state_t next_round_key(input state_t p, input logic [7:0] rcon);
    state_t q;
    q[15] = gb(p, 0) ^ sbox(gb(p, 13)) ^ rcon;
    q[14] = gb(p, 1) ^ sbox(gb(p, 14));
    q[13] = gb(p, 2) ^ sbox(gb(p, 15));
    q[12] = gb(p, 3) ^ sbox(gb(p, 12));
    for (int i = 4; i < 16; i++) q[15 - i] = gb(p, i) ^ q[15 - (i - 4)];
    next_round_key = q;
  endfunction

  // invert one key step: recover the previous round key
  function automatic state_t prev_round_key(input state_t q, input logic [7:0] rcon);
    state_t p;
    for (int i = 4; i < 16; i++) p[15 - i] = gb(q, i) ^ gb(q, i - 4);
    p[15] = gb(q, 0) ^ sbox(p[15 - 13]) ^ rcon;
    p[14] = gb(q, 1) ^ sbox(p[15 - 14]);
    p[13] = gb(q, 2) ^ sbox(p[15 - 15]);
    p[12] = gb(q, 3) ^ sbox(p[15 - 12]);
    prev_round_key = p;
  endfunction

  function automatic state_t enc_round(input state_t s, input state_t k, input logic last);
    state_t t;
    state_t m;
    logic [7:0] a0, a1, a2, a3;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        t[15 - (r + 4 * c)] = sbox(gb(s, r + 4 * ((c + r) % 4)));
    m = t;
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = gb(t, 4 * c); a1 = gb(t, 4 * c + 1);
        a2 = gb(t, 4 * c + 2); a3 = gb(t, 4 * c + 3);
        m[15 - 4 * c]       = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
        m[15 - (4 * c + 1)] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
        m[15 - (4 * c + 2)] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
        m[15 - (4 * c + 3)] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
    end
    enc_round = m ^ k;
  endfunction

  function automatic state_t dec_round(input state_t s, input state_t k, input logic last);
    state_t t;
    state_t m;
    logic [7:0] a0, a1, a2, a3;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        t[15 - (r + 4 * ((c + r) % 4))] = inv_sbox(gb(s, r + 4 * c));
    t = t ^ k;
    m = t;
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = gb(t, 4 * c); a1 = gb(t, 4 * c + 1);
        a2 = gb(t, 4 * c + 2); a3 = gb(t, 4 * c + 3);
        m[15 - 4 * c] = gf_mul(8'h0e, a0) ^ gf_mul(8'h0b, a1) ^ gf_mul(8'h0d, a2)
                      ^ gf_mul(8'h09, a3);
        m[15 - (4 * c + 1)] = gf_mul(8'h09, a0) ^ gf_mul(8'h0e, a1) ^ gf_mul(8'h0b, a2)
                            ^ gf_mul(8'h0d, a3);
        m[15 - (4 * c + 2)] = gf_mul(8'h0d, a0) ^ gf_mul(8'h09, a1) ^ gf_mul(8'h0e, a2)
                            ^ gf_mul(8'h0b, a3);
        m[15 - (4 * c + 3)] = gf_mul(8'h0b, a0) ^ gf_mul(8'h0d, a1) ^ gf_mul(8'h09, a2)
                            ^ gf_mul(8'h0e, a3);
      end
    end
    dec_round = m;
  endfunction

endpackage

// ===== sv/aes_keysched.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES key schedule
// Expands the cipher key one round a cycle into a registered key table.
// ----------------------------------------------------------------------------
module aes_keysched (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic                            cfg_idx,
  input  logic [63:0]                     cfg_data,
  output logic                            ready,
  output aes_pkg::state_t [aes_pkg::NumRounds:0] rk
);
  import aes_pkg::*;

  localparam int unsigned CntW = $clog2(NumRounds + 1);

  state_t                 rk_r [NumRounds + 1];
  logic [CntW-1:0]        cnt_r;
  logic [7:0]             rcon_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rk_r[0] <= '0;
      cnt_r   <= CntW'(1);
      rcon_r  <= 8'h01;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_KEY_HIGH) rk_r[0][15:8] <= cfg_data;
      else rk_r[0][7:0] <= cfg_data;
      cnt_r  <= CntW'(1);
      rcon_r <= 8'h01;
    end else if (cnt_r <= CntW'(NumRounds)) begin
      rk_r[cnt_r] <= next_round_key(rk_r[cnt_r - CntW'(1)], rcon_r);
      rcon_r      <= xtime(rcon_r);
      cnt_r       <= cnt_r + CntW'(1);
    end
  end

  assign ready = (cnt_r > CntW'(NumRounds));

  always_comb begin
    for (int i = 0; i <= NumRounds; i++) rk[i] = rk_r[i];
  end

endmodule

// ===== sv/aes_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES front end
// Accepts items, classifies the direction, whitens and queues them.
// ----------------------------------------------------------------------------
module aes_front #(
  parameter int unsigned DEPTH = aes_pkg::QueueDepth
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  aes_pkg::in_item_t in_item,
  input  aes_pkg::state_t   k0,
  input  aes_pkg::state_t   k10,
  input  logic              key_ready,
  output logic              job_vld,
  output aes_pkg::job_t     job,
  input  logic              job_take
);
  import aes_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  job_t          q_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          wr, rd;
  job_t          j;

  always_comb begin
    j.dec = in_item.kind;
    j.blk = {in_item.block_high, in_item.block_low} ^ (in_item.kind ? k10 : k0);
  end

  assign full    = (cnt_r == (AW+1)'(DEPTH)) || !key_ready;
  assign wr      = push && !full;
  assign job_vld = (cnt_r != '0);
  assign rd      = job_vld && job_take;
  assign job     = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) q_r[wp_r] <= j;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
      if (rd) rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

endmodule

// ===== sv/aes_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES round pipeline
// Ten round stages plus an output queue with stall-aware credit.
// ----------------------------------------------------------------------------
module aes_back #(
  parameter int unsigned DEPTH = aes_pkg::QueueDepth
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    job_vld,
  input  aes_pkg::job_t                           job,
  output logic                                    job_take,
  input  aes_pkg::state_t [aes_pkg::NumRounds:0]  rk,
  output logic                                    out_empty,
  input  logic                                    out_pop,
  output aes_pkg::out_item_t                      out_item
);
  import aes_pkg::*;

  localparam int unsigned OD = NumRounds + DEPTH;
  localparam int unsigned AW = $clog2(OD);
  localparam int unsigned CW = $clog2(OD + 1);

  logic   vld_r [NumRounds];
  job_t   st_r  [NumRounds];
  state_t oq_r  [OD];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r, fly_r;
  logic          rd;

  // credit: queued plus in flight must fit the output queue
  assign job_take = job_vld && ((cnt_r + fly_r) < CW'(OD));
  assign rd       = out_pop && !out_empty;
  assign out_empty = (cnt_r == '0);
  assign out_item = oq_r[rp_r];

  always_ff @(posedge clk) begin
    st_r[0].dec <= job.dec;
    st_r[0].blk <= job.dec ? dec_round(job.blk, rk[NumRounds-1], 1'b0)
                           : enc_round(job.blk, rk[1], 1'b0);
    for (int i = 1; i < NumRounds; i++) begin
      st_r[i].dec <= st_r[i-1].dec;
      st_r[i].blk <= st_r[i-1].dec
        ? dec_round(st_r[i-1].blk, rk[NumRounds-1-i], i == NumRounds-1)
        : enc_round(st_r[i-1].blk, rk[i+1], i == NumRounds-1);
    end
    if (vld_r[NumRounds-1]) oq_r[wp_r] <= st_r[NumRounds-1].blk;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumRounds; i++) vld_r[i] <= 1'b0;
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
      fly_r <= '0;
    end else begin
      vld_r[0] <= job_take;
      for (int i = 1; i < NumRounds; i++) vld_r[i] <= vld_r[i-1];
      fly_r <= fly_r + CW'(job_take) - CW'(vld_r[NumRounds-1]);
      if (vld_r[NumRounds-1]) wp_r <= (wp_r == AW'(OD - 1)) ? '0 : wp_r + AW'(1);
      if (rd) rp_r <= (rp_r == AW'(OD - 1)) ? '0 : rp_r + AW'(1);
      cnt_r <= cnt_r + CW'(vld_r[NumRounds-1]) - CW'(rd);
    end
  end

endmodule

// ===== sv/aes128_block_cipher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 block cipher
// Encrypts or decrypts one 128-bit block per item with a configured key.
// ----------------------------------------------------------------------------
// Channel   Ports                         Accepted when
// input     in_push/in_full/in_item       in_push && !in_full
// result    out_pop/out_empty/out_item    out_pop && !out_empty
// config    cfg_we/cfg_idx/cfg_data       cfg_we
//
// One item per cycle while results are popped; items pass the ten round stages.
// After reset or a key write in_full is held high until the schedule is ready.
// A stalled result side fills the output queue, then the input queue, then
// raises in_full.
module aes128_block_cipher #(
  parameter int unsigned DEPTH = aes_pkg::QueueDepth
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  aes_pkg::in_item_t  in_item,
  output logic               out_empty,
  input  logic               out_pop,
  output aes_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic               cfg_idx,
  input  logic [63:0]        cfg_data
);
  import aes_pkg::*;

  state_t [NumRounds:0] rk;
  logic                 key_ready;
  logic                 job_vld, job_take;
  job_t                 job;

  aes_keysched u_keys (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_data, .ready(key_ready), .rk
  );

  aes_front #(.DEPTH(DEPTH)) u_front (
    .clk, .rst_n, .push(in_push), .full(in_full), .in_item,
    .k0(rk[0]), .k10(rk[NumRounds]), .key_ready,
    .job_vld, .job, .job_take
  );

  aes_back #(.DEPTH(DEPTH)) u_back (
    .clk, .rst_n, .job_vld, .job, .job_take, .rk,
    .out_empty, .out_pop, .out_item
  );

endmodule

// ===== sv/aes_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES port checker
// Watches the top-level ports for handshake, key-write and reset slips.
// ----------------------------------------------------------------------------
`include "aes128_block_cipher_defines.svh"
module aes_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_full,
  input logic               out_empty,
  input logic               out_pop,
  input aes_pkg::out_item_t out_item,
  input logic               cfg_we
);
  // a waiting result holds until taken
  `AES_ASSERT_NXT(a_hold, clk, rst_n, !out_empty && !out_pop, !out_empty && $stable(out_item))
  // a key write blocks input on the next cycle
  `AES_ASSERT_NXT(a_cfg_full, clk, rst_n, cfg_we, in_full)
  // a result cannot appear right after reset
  `AES_ASSERT_IMP(a_rst_empty, clk, rst_n, $rose(rst_n), out_empty)
endmodule

bind aes128_block_cipher aes_checker u_chk (
  .clk, .rst_n, .in_full, .out_empty, .out_pop, .out_item, .cfg_we
);
